@@ src/shuf_pkg.sv @@
package shuf_pkg;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_ABSENT   = 2'd3
    } status_t;

    // request codes (code 3 is unused and answers with STATUS_OK)
    localparam logic [1:0] REQ_COUNT  = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_ENCODE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // fixed field widths
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned SYMBOL_W   = 7;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CODE_OUT_W = 16;
    localparam int unsigned LEN_OUT_W  = 5;

endpackage

@@ src/shuf_ram.sv @@
module shuf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/static_huffman_encoder_core.sv @@
// channel  | tvalid/tready | tdata                          | tuser
// s_ (in)  | s_tvalid      | [6:0] symbol, [7] zero         | [1:0] req_type
// m_ (out) | m_tvalid      | [15:0] code_bits, [20:16]      | [1:0] status
//          |               | code_length, [23:21] zero      |
//
// one transaction at a time: a count passes a read and a write state, an encode
// a read and a check state; a request with type 3 or an early answer goes from
// idle straight to the done state, which loads the output register
// a build sweeps all 2*ALPHABET-1 nodes (a read and a write state each), then
// for each merge runs two min-search scans over the nodes created so far on the
// one shared weight comparator, then walks every present symbol to the root
// through a step and a wait state per level; the scans dominate
// reset clears control, the histogram valid bits and message length at once
// the output register holds a result while m_tready is low and the next
// transaction can be taken meanwhile; a further result waits in the done state
module static_huffman_encoder_core #(
    parameter int unsigned ALPHABET     = 128,
    parameter int unsigned MAX_LEN      = 1024,
    parameter int unsigned MAX_CODE_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] symbol
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] code_bits, [20:16] code_length
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int unsigned NODES  = 2 * ALPHABET - 1;
    localparam int unsigned NODE_W = $clog2(NODES);
    localparam int unsigned SYM_W  = $clog2(ALPHABET);
    localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned CW     = MAX_CODE_LEN;
    localparam int unsigned LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned LIVE_W = SYM_W + 1;

    typedef enum logic [15:0] {
        ST_IDLE      = 16'h0001,
        ST_CNT_RD    = 16'h0002,
        ST_CNT_WR    = 16'h0004,
        ST_ENC_RD    = 16'h0008,
        ST_ENC_CHK   = 16'h0010,
        ST_INIT_RD   = 16'h0020,
        ST_INIT_WR   = 16'h0040,
        ST_LONE      = 16'h0080,
        ST_SCAN      = 16'h0100,
        ST_KILL      = 16'h0200,
        ST_MERGE_A   = 16'h0400,
        ST_MERGE_B   = 16'h0800,
        ST_WALK      = 16'h1000,
        ST_STEP      = 16'h2000,
        ST_STEP_WAIT = 16'h4000,
        ST_DONE      = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [shuf_pkg::SYMBOL_W-1:0] sym_reg, sym_next;
    logic [NODE_W-1:0]   idx_reg, idx_next;        // init sweep and scan pointer
    logic                pipe_v_reg, pipe_v_next;  // scan read in flight
    logic                best_v_reg, best_v_next;
    logic [NODE_W-1:0]   best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]    best_w_reg, best_w_next;
    logic [NODE_W-1:0]   pipe_idx_reg, pipe_idx_next;
    logic                pick_reg, pick_next;      // second lightest node
    logic [NODE_W-1:0]   a_idx_reg, a_idx_next;
    logic [CNT_W-1:0]    a_w_reg, a_w_next;
    logic [NODE_W-1:0]   next_reg, next_next;      // next internal node number
    logic [NODE_W-1:0]   root_reg, root_next;
    logic [LIVE_W-1:0]   live_cnt_reg, live_cnt_next;
    logic [SYM_W-1:0]    s_reg, s_next;            // walk symbol
    logic [NODE_W-1:0]   n_reg, n_next;            // walk node
    logic [LEN_W-1:0]    k_reg, k_next;            // walk depth
    logic [CW-1:0]       code_reg, code_next;
    logic [CNT_W-1:0]    msg_len_reg, msg_len_next;
    logic                built_reg, built_next;
    logic [ALPHABET-1:0] cnt_vld_reg, cnt_vld_next;
    shuf_pkg::status_t   res_status_reg, res_status_next;
    logic [CW-1:0]       res_bits_reg, res_bits_next;
    logic [LEN_W-1:0]    res_len_reg, res_len_next;
    logic                out_vld_reg, out_vld_next;
    shuf_pkg::status_t   out_status_reg, out_status_next;
    logic [shuf_pkg::CODE_OUT_W-1:0] out_bits_reg, out_bits_next;
    logic [shuf_pkg::LEN_OUT_W-1:0]  out_len_reg, out_len_next;

    // memory ports
    logic              cnt_we;
    logic [SYM_W-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic              wt_we;
    logic [NODE_W-1:0] wt_waddr, wt_raddr;
    logic [CNT_W-1:0]  wt_wdata, wt_rdata;
    logic              live_we;
    logic [NODE_W-1:0] live_waddr, live_raddr;
    logic              live_wdata, live_rdata;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr, link_raddr;
    logic [NODE_W:0]   link_wdata, link_rdata;     // {second child, parent}
    logic              code_we;
    logic [SYM_W-1:0]  tab_waddr, tab_raddr;
    logic [CW-1:0]     code_wdata, code_rdata;
    logic              len_we;
    logic [LEN_W-1:0]  len_wdata, len_rdata;

    logic [SYM_W-1:0]  sym_idx;
    logic              in_take;
    logic              issuing;
    logic              present;
    logic [LIVE_W-1:0] live_total;
    logic [CW+15:0]    bits_wide;
    logic [LEN_W+4:0]  len_wide;

    assign sym_idx   = SYM_W'(sym_reg);
    assign in_take   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign bits_wide = {16'd0, res_bits_reg};
    assign len_wide  = {5'd0, res_len_reg};

    shuf_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    shuf_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_wt_ram (
        .aclk(aclk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );
    shuf_ram #(.WIDTH(1), .DEPTH(NODES)) u_live_ram (
        .aclk(aclk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
        .raddr(live_raddr), .rdata(live_rdata)
    );
    shuf_ram #(.WIDTH(NODE_W + 1), .DEPTH(NODES)) u_link_ram (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );
    shuf_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_code_ram (
        .aclk(aclk), .we(code_we), .waddr(tab_waddr), .wdata(code_wdata),
        .raddr(tab_raddr), .rdata(code_rdata)
    );
    shuf_ram #(.WIDTH(LEN_W), .DEPTH(ALPHABET)) u_len_ram (
        .aclk(aclk), .we(len_we), .waddr(tab_waddr), .wdata(len_wdata),
        .raddr(tab_raddr), .rdata(len_rdata)
    );

    // fixed read addresses per state
    assign cnt_raddr  = (state_reg == ST_INIT_RD) ? SYM_W'(idx_reg) : sym_idx;
    assign wt_raddr   = idx_reg;
    assign live_raddr = idx_reg;
    assign link_raddr = n_reg;
    assign tab_raddr  = sym_idx;
    assign issuing    = (idx_reg < next_reg);
    assign present    = (idx_reg < NODE_W'(ALPHABET)) && cnt_vld_reg[SYM_W'(idx_reg)];
    assign live_total = live_cnt_reg + LIVE_W'(present);

    always_comb begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        idx_next        = idx_reg;
        pipe_v_next     = pipe_v_reg;
        pipe_idx_next   = pipe_idx_reg;
        best_v_next     = best_v_reg;
        best_idx_next   = best_idx_reg;
        best_w_next     = best_w_reg;
        pick_next       = pick_reg;
        a_idx_next      = a_idx_reg;
        a_w_next        = a_w_reg;
        next_next       = next_reg;
        root_next       = root_reg;
        live_cnt_next   = live_cnt_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        code_next       = code_reg;
        msg_len_next    = msg_len_reg;
        built_next      = built_reg;
        cnt_vld_next    = cnt_vld_reg;
        res_status_next = res_status_reg;
        res_bits_next   = res_bits_reg;
        res_len_next    = res_len_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_status_next = out_status_reg;
        out_bits_next   = out_bits_reg;
        out_len_next    = out_len_reg;

        cnt_we     = 1'b0;
        cnt_waddr  = sym_idx;
        cnt_wdata  = cnt_rdata + CNT_W'(1);
        wt_we      = 1'b0;
        wt_waddr   = idx_reg;
        wt_wdata   = cnt_rdata;
        live_we    = 1'b0;
        live_waddr = idx_reg;
        live_wdata = present;
        link_we    = 1'b0;
        link_waddr = a_idx_reg;
        link_wdata = {1'b0, next_reg};
        code_we    = 1'b0;
        len_we     = 1'b0;
        tab_waddr  = s_reg;
        code_wdata = code_reg;
        len_wdata  = k_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    sym_next        = s_tdata[shuf_pkg::SYMBOL_W-1:0];
                    res_status_next = shuf_pkg::STATUS_OK;
                    res_bits_next   = '0;
                    res_len_next    = '0;
                    state_next      = ST_DONE;
                    case (s_tuser)
                        shuf_pkg::REQ_COUNT: begin
                            if (int'(msg_len_reg) >= MAX_LEN) begin
                                res_status_next = shuf_pkg::STATUS_TOO_LONG;
                            end else if (int'(s_tdata[shuf_pkg::SYMBOL_W-1:0]) < ALPHABET) begin
                                state_next = ST_CNT_RD;
                            end
                        end
                        shuf_pkg::REQ_BUILD: begin
                            built_next    = 1'b0;
                            idx_next      = '0;
                            live_cnt_next = '0;
                            state_next    = ST_INIT_RD;
                        end
                        shuf_pkg::REQ_ENCODE: begin
                            if (!built_reg) begin
                                res_status_next = shuf_pkg::STATUS_EMPTY;
                            end else if (int'(s_tdata[shuf_pkg::SYMBOL_W-1:0]) >= ALPHABET) begin
                                res_status_next = shuf_pkg::STATUS_ABSENT;
                            end else begin
                                state_next = ST_ENC_RD;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CNT_RD: begin
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                // histogram entries that were never written read as zero
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_vld_reg[sym_idx] ? cnt_rdata : '0) + CNT_W'(1);
                cnt_vld_next[sym_idx] = 1'b1;
                msg_len_next = msg_len_reg + CNT_W'(1);
                built_next   = 1'b0;
                state_next   = ST_DONE;
            end
            ST_ENC_RD: begin
                state_next = ST_ENC_CHK;
            end
            ST_ENC_CHK: begin
                if (!cnt_vld_reg[sym_idx]) begin
                    res_status_next = shuf_pkg::STATUS_ABSENT;
                end else begin
                    res_bits_next = code_rdata;
                    res_len_next  = len_rdata;
                end
                state_next = ST_DONE;
            end
            ST_INIT_RD: begin
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                // load leaves from the histogram, mark internal nodes dead
                wt_we   = 1'b1;
                live_we = 1'b1;
                live_cnt_next = live_total;
                if (present) begin
                    root_next = idx_reg;
                end
                if (int'(idx_reg) == NODES - 1) begin
                    if (live_total == '0) begin
                        res_status_next = shuf_pkg::STATUS_EMPTY;
                        state_next      = ST_DONE;
                    end else if (live_total == LIVE_W'(1)) begin
                        state_next = ST_LONE;
                    end else begin
                        next_next   = NODE_W'(ALPHABET);
                        idx_next    = '0;
                        pipe_v_next = 1'b0;
                        best_v_next = 1'b0;
                        pick_next   = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end else begin
                    idx_next   = idx_reg + NODE_W'(1);
                    state_next = ST_INIT_RD;
                end
            end
            ST_LONE: begin
                // a single present symbol gets the one-bit code 0
                code_we    = 1'b1;
                len_we     = 1'b1;
                tab_waddr  = SYM_W'(root_reg);
                code_wdata = '0;
                len_wdata  = LEN_W'(1);
                built_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // one node per cycle through the shared weight comparator
                pipe_v_next   = issuing;
                pipe_idx_next = idx_reg;
                if (issuing) begin
                    idx_next = idx_reg + NODE_W'(1);
                end
                if (pipe_v_reg && live_rdata && (!best_v_reg || wt_rdata < best_w_reg)) begin
                    best_v_next   = 1'b1;
                    best_idx_next = pipe_idx_reg;
                    best_w_next   = wt_rdata;
                end
                if (!issuing && !pipe_v_reg) begin
                    state_next = ST_KILL;
                end
            end
            ST_KILL: begin
                live_we    = 1'b1;
                live_waddr = best_idx_reg;
                live_wdata = 1'b0;
                if (!pick_reg) begin
                    a_idx_next  = best_idx_reg;
                    a_w_next    = best_w_reg;
                    pick_next   = 1'b1;
                    idx_next    = '0;
                    best_v_next = 1'b0;
                    pipe_v_next = 1'b0;
                    state_next  = ST_SCAN;
                end else begin
                    state_next = ST_MERGE_A;
                end
            end
            ST_MERGE_A: begin
                wt_we      = 1'b1;
                wt_waddr   = next_reg;
                wt_wdata   = CNT_W'(a_w_reg + best_w_reg);
                live_we    = 1'b1;
                live_waddr = next_reg;
                live_wdata = 1'b1;
                link_we    = 1'b1;
                state_next = ST_MERGE_B;
            end
            ST_MERGE_B: begin
                link_we       = 1'b1;
                link_waddr    = best_idx_reg;
                link_wdata    = {1'b1, next_reg};
                root_next     = next_reg;
                next_next     = next_reg + NODE_W'(1);
                live_cnt_next = live_cnt_reg - LIVE_W'(1);
                if (live_cnt_reg > LIVE_W'(2) && int'(next_reg) + 1 < NODES) begin
                    idx_next    = '0;
                    pipe_v_next = 1'b0;
                    best_v_next = 1'b0;
                    pick_next   = 1'b0;
                    state_next  = ST_SCAN;
                end else begin
                    s_next     = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (cnt_vld_reg[s_reg]) begin
                    n_next     = NODE_W'(s_reg);
                    k_next     = '0;
                    code_next  = '0;
                    state_next = ST_STEP;
                end else if (int'(s_reg) == ALPHABET - 1) begin
                    built_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    s_next = s_reg + SYM_W'(1);
                end
            end
            ST_STEP: begin
                if (n_reg == root_reg) begin
                    code_we = 1'b1;
                    len_we  = 1'b1;
                    if (int'(s_reg) == ALPHABET - 1) begin
                        built_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        s_next     = s_reg + SYM_W'(1);
                        state_next = ST_WALK;
                    end
                end else if (int'(k_reg) >= MAX_CODE_LEN) begin
                    // codeword would not fit: abandon the table
                    res_status_next = shuf_pkg::STATUS_TOO_LONG;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_STEP_WAIT;
                end
            end
            ST_STEP_WAIT: begin
                code_next  = code_reg | (CW'(link_rdata[NODE_W]) << k_reg);
                k_next     = k_reg + LEN_W'(1);
                n_next     = link_rdata[NODE_W-1:0];
                state_next = ST_STEP;
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_bits_next   = bits_wide[15:0];
                    out_len_next    = len_wide[4:0];
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pipe_v_reg   <= 1'b0;
            msg_len_reg  <= '0;
            built_reg    <= 1'b0;
            cnt_vld_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pipe_v_reg   <= pipe_v_next;
            msg_len_reg  <= msg_len_next;
            built_reg    <= built_next;
            cnt_vld_reg  <= cnt_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg        <= sym_next;
        idx_reg        <= idx_next;
        pipe_idx_reg   <= pipe_idx_next;
        best_v_reg     <= best_v_next;
        best_idx_reg   <= best_idx_next;
        best_w_reg     <= best_w_next;
        pick_reg       <= pick_next;
        a_idx_reg      <= a_idx_next;
        a_w_reg        <= a_w_next;
        next_reg       <= next_next;
        root_reg       <= root_next;
        live_cnt_reg   <= live_cnt_next;
        s_reg          <= s_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        code_reg       <= code_next;
        res_status_reg <= res_status_next;
        res_bits_reg   <= res_bits_next;
        res_len_reg    <= res_len_next;
        out_status_reg <= out_status_next;
        out_bits_reg   <= out_bits_next;
        out_len_reg    <= out_len_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'd0, out_len_reg, out_bits_reg};

    // one transaction in flight: no second accept right after the first
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    // message length only ever steps up by one
    a_len_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (msg_len_reg != $past(msg_len_reg)) |-> (msg_len_reg == $past(msg_len_reg) + CNT_W'(1)))
        else $error("message length jumped");

    // message length never passes its limit
    a_len_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(msg_len_reg) <= MAX_LEN)
        else $error("message length beyond limit");

    // a non-ok result carries no codeword
    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != shuf_pkg::STATUS_OK)) |-> (out_len_reg == '0 && out_bits_reg == '0))
        else $error("codeword on an error result");

    // a built table never holds a codeword longer than allowed
    a_code_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(out_len_reg) <= MAX_CODE_LEN))
        else $error("code length out of range");

endmodule
